// File: hw/rtl/bncm_pkg.sv
// Shared constants, word types and the row dilation and candidate functions for the candidate mask block.
package bncm_pkg;

  // Board geometry
  localparam int BOARD_WIDTH = 19;
  localparam int FIELD_W     = 19;
  localparam int IDX_W       = 5;
  localparam int MASK_BITS   = (BOARD_WIDTH < FIELD_W) ? BOARD_WIDTH : FIELD_W;
  localparam int CNT_W       = $clog2(BOARD_WIDTH);

  // Columns that exist on the board, within the field width
  localparam logic [FIELD_W-1:0] ROW_MASK =
    FIELD_W'((({(FIELD_W+1){1'b0}} | (FIELD_W+1)'(1)) << MASK_BITS) - (FIELD_W+1)'(1));

  // Result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [FIELD_W-1:0] first_player_row;
    logic [FIELD_W-1:0] second_player_row;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   row_index;
    logic [FIELD_W-1:0] candidate_mask;
    logic               board_done;
  } out_word_t;

  // Which of the two result slots an accepted row produces
  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

  // Horizontal spread of an occupancy row by one column each way
  function automatic logic [FIELD_W-1:0] spread(input logic [FIELD_W-1:0] occ);
    spread = occ | (occ << 1) | (occ >> 1);
  endfunction

  // Empty cells of the center row with an occupied neighbor
  function automatic logic [FIELD_W-1:0] candidates(input logic [FIELD_W-1:0] above,
                                                    input logic [FIELD_W-1:0] center,
                                                    input logic [FIELD_W-1:0] below);
    candidates = (spread(above) | spread(center) | spread(below)) & ~center & ROW_MASK;
  endfunction

endpackage

// File: hw/rtl/board_neighbor_candidate_mask.sv
// Top level of the board neighbor candidate mask block.
//
//  channel | ports                          | word
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data    | in_word_t: two player rows
//  result  | out_valid, out_ready, out_data | out_word_t: row, mask, done
//
// One row word is accepted per clock while in_ready is high; its results go
// into a four-word register queue. A first row gives no word, a middle row one,
// the final row of a board two, which the queue hands out one per cycle while
// out_ready is high. in_ready is high while the queue has room for two words,
// so it depends on queue fill only, never on out_ready in the same cycle. Reset
// is synchronous on rst_n and empties the queue and the row window.
module board_neighbor_candidate_mask import bncm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  push_t     push;
  out_word_t res_a;
  out_word_t res_b;
  logic      accept;

  assign accept = in_valid && in_ready;

  // Row window and mask logic
  bncm_row_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_data),
    .push    (push),
    .res_a   (res_a),
    .res_b   (res_b)
  );

  // Result queue
  bncm_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/bncm_row_engine.sv
// Row window registers, row counter and the per-row candidate mask logic.
module bncm_row_engine import bncm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_word_t  in_word,
  output push_t     push,
  output out_word_t res_a,
  output out_word_t res_b
);

  logic [FIELD_W-1:0] recent_r, recent_nxt;
  logic [FIELD_W-1:0] older_r, older_nxt;
  logic [CNT_W-1:0]   rows_r, rows_nxt;
  logic [FIELD_W-1:0] cur_occ;
  logic               first_row;
  logic               last_row;

  // Occupancy of the incoming row, off-board columns dropped
  assign cur_occ   = (in_word.first_player_row | in_word.second_player_row) & ROW_MASK;
  assign first_row = (rows_r == '0);
  assign last_row  = (rows_r == CNT_W'(BOARD_WIDTH - 1));

  // Result for the previous row, and for the final row itself
  always_comb begin
    res_a.row_index      = IDX_W'(32'(rows_r) - 32'd1);
    res_a.candidate_mask = candidates(older_r, recent_r, cur_occ);
    res_a.board_done     = 1'b0;
    res_b.row_index      = IDX_W'(32'(rows_r));
    res_b.candidate_mask = candidates(recent_r, cur_occ, '0);
    res_b.board_done     = 1'b1;
    push.push_a          = accept && !first_row;
    push.push_b          = accept && last_row;
  end

  // Window and counter update
  always_comb begin
    recent_nxt = recent_r;
    older_nxt  = older_r;
    rows_nxt   = rows_r;
    if (accept) begin
      if (first_row) begin
        older_nxt  = '0;
        recent_nxt = cur_occ;
        rows_nxt   = CNT_W'(1);
      end else if (last_row) begin
        older_nxt  = '0;
        recent_nxt = '0;
        rows_nxt   = '0;
      end else begin
        older_nxt  = recent_r;
        recent_nxt = cur_occ;
        rows_nxt   = rows_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      older_r  <= '0;
      rows_r   <= '0;
    end else begin
      recent_r <= recent_nxt;
      older_r  <= older_nxt;
      rows_r   <= rows_nxt;
    end
  end

endmodule

// File: hw/rtl/bncm_out_queue.sv
// Small shifting result queue: up to two pushes and one pop per cycle.
module bncm_out_queue import bncm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  input  out_word_t res_a,
  input  out_word_t res_b,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  out_word_t          slot_r   [QUEUE_DEPTH];
  out_word_t          slot_nxt [QUEUE_DEPTH];
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               pop;

  assign out_valid = (count_r != '0);
  assign out_data  = slot_r[0];
  assign pop       = out_valid && out_ready;
  // Room for the two words of a final row
  assign room      = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));

  // Shift out the head, then append the new words at the tail
  always_comb begin
    slot_nxt  = slot_r;
    count_nxt = count_r;
    if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
      count_nxt = count_nxt - QCNT_W'(1);
    end
    if (push.push_a) begin
      slot_nxt[count_nxt[QIDX_W-1:0]] = res_a;
      count_nxt = count_nxt + QCNT_W'(1);
    end
    if (push.push_b) begin
      slot_nxt[count_nxt[QIDX_W-1:0]] = res_b;
      count_nxt = count_nxt + QCNT_W'(1);
    end
  end

  // Payload slots need no reset
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
